FILE: rtl/core/top_k_select_with_dedup_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-k selection block
// Each macro clocks on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SELECT_WITH_DEDUP_TOP_ASSERT_SVH
`define TOP_K_SELECT_WITH_DEDUP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TKSD_ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("property violated");
`define TKSD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TKSD_ASSERT_PROP(label, prop)
`define TKSD_ASSERT_NEVER(label, cond)
`endif
`endif

FILE: rtl/core/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared widths, limits and request types of the top-k selection block.
// ----------------------------------------------------------------------------
`default_nettype none
package tksd_pkg;

  localparam int KEY_W             = 63;
  localparam int SEQ_W             = 16;
  localparam int TAG_W             = 8;
  localparam int CNT_W             = 7;
  localparam int RESULT_LIMIT      = 64;
  localparam int GROUP_DEPTH_DEF   = 64;
  localparam int QUEUE_DEPTH       = 4;

  typedef struct packed {
    logic [KEY_W-1:0] score_key;
    logic [SEQ_W-1:0] sequence_ident;
    logic [TAG_W-1:0] record_tag;
    logic             group_end;
  } in_req_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic [KEY_W-1:0] out_key;
    logic [SEQ_W-1:0] out_sequence;
    logic             out_last;
    logic             overflowed;
  } out_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
    logic [TAG_W-1:0] tag;
  } rec_t;

endpackage
`default_nettype wire

FILE: rtl/core/top_k_select_with_dedup_top.sv
// ----------------------------------------------------------------------------
// top_k_select_with_dedup_top
// Per-group top-k selection by ascending key with duplicate sequence removal.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid / in_ready        in_req  (in_req_t)
//   out       output     out_valid / out_ready      out_req (out_req_t)
//   cfg       input      cfg_write_en (no wait)     cfg_write_data (top_count)
//
// Candidates are taken at one request per cycle into a four-entry queue while
// it has room, and drained into the entry memory at one per cycle while the
// engine is idle, so loading runs at stream rate. At group end the engine runs
// one selection scan per considered rank through the single read port of the
// entry memory, plus a duplicate check against the emitted list.
// Reset is synchronous; no memory clearing pass is needed after it.
// A stalled output holds the engine only at the point where it must emit.
// ----------------------------------------------------------------------------
`default_nettype none
module top_k_select_with_dedup_top
  import tksd_pkg::*;
#(
  parameter int GROUP_DEPTH = GROUP_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write_en,
  input  wire logic [CNT_W-1:0] cfg_write_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_req_t          in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_req_t              out_req
);

  // The number of best-ranked records considered per group.
  logic [CNT_W-1:0] top_count;

  // Queue between the accepting front and the selection engine.
  logic    q_valid;
  logic    q_ready;
  in_req_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= CNT_W'(1);
    end else if (cfg_write_en) begin
      top_count <= cfg_write_data;
    end
  end

  tksd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  // The engine holds the group, ranks it and emits the selected records.
  tksd_back #(
    .GROUP_DEPTH (GROUP_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .top_count (top_count),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
  );

endmodule
`default_nettype wire

FILE: rtl/core/tksd_front.sv
// ----------------------------------------------------------------------------
// tksd_front
// Accepts input requests and queues them for the selection engine.
// ----------------------------------------------------------------------------
`default_nettype none
module tksd_front
  import tksd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_req_t in_req,
  output logic         q_valid,
  input  wire logic    q_ready,
  output in_req_t      q_data
);

  localparam int QW = $clog2(QUEUE_DEPTH);

  in_req_t         fifo [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [QW:0]     count;
  logic            push;
  logic            pop;

  assign in_ready = (count != (QW+1)'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_data   = fifo[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_req;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tksd_back.sv
// ----------------------------------------------------------------------------
// tksd_back
// Holds a group, then ranks it by repeated selection scans and emits the
// best records while skipping repeated sequence identifiers.
// ----------------------------------------------------------------------------
`default_nettype none
module tksd_back
  import tksd_pkg::*;
#(
  parameter int GROUP_DEPTH = GROUP_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] top_count,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire in_req_t          q_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_req_t              out_req
);

  localparam int IW  = $clog2(GROUP_DEPTH);
  localparam int CW  = $clog2(GROUP_DEPTH + 1);
  localparam int MW  = (CW > CNT_W) ? CW : CNT_W;
  localparam int EIW = $clog2(RESULT_LIMIT);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DUP, ST_STORE, ST_FLUSH
  } state_t;

  state_t           state;
  rec_t             ent_mem [GROUP_DEPTH];
  rec_t             ent_rd;
  logic [SEQ_W-1:0] em_mem [RESULT_LIMIT];
  logic [SEQ_W-1:0] em_rd;

  logic [CW-1:0]    held;
  logic             ovf;
  logic [CNT_W-1:0] cons;
  logic [CNT_W-1:0] rank;
  logic [CNT_W-1:0] emitted;
  logic [CW-1:0]    scan_addr;
  logic             rd_pend;
  logic [IW-1:0]    rd_idx;
  logic [CNT_W-1:0] dup_addr;
  logic             em_pend;
  logic             is_dup;
  rec_t             best;
  logic [IW-1:0]    best_idx;
  logic             best_found;
  logic [KEY_W-1:0] prev_key;
  logic [IW-1:0]    prev_idx;
  logic             have_prev;
  rec_t             pend;
  logic             pend_valid;

  logic             slot_free;
  logic             ent_we;
  logic             em_we;
  logic             store_go;
  logic             emit_now;
  logic [CW-1:0]    held_new;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cons_new;
  logic             after_prev;
  logic [CNT_W-1:0] rank_next;

  assign q_ready   = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign ent_we    = (state == ST_IDLE) && q_valid && (held < CW'(GROUP_DEPTH));
  assign store_go  = (state == ST_STORE) && (!pend_valid || slot_free);
  assign emit_now  = (store_go && pend_valid) || ((state == ST_FLUSH) && slot_free);
  assign em_we     = store_go;
  assign held_new  = held + CW'(ent_we);
  assign rank_next = rank + 1'b1;

  always_comb begin
    if (top_count == '0) begin
      lim = CNT_W'(1);
    end else if (top_count > CNT_W'(RESULT_LIMIT)) begin
      lim = CNT_W'(RESULT_LIMIT);
    end else begin
      lim = top_count;
    end
    cons_new = (MW'(held_new) < MW'(lim)) ? CNT_W'(held_new) : lim;
    after_prev = !have_prev || (ent_rd.key > prev_key) ||
                 ((ent_rd.key == prev_key) && (rd_idx > prev_idx));
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[held[IW-1:0]] <= '{key: q_data.score_key, seq: q_data.sequence_ident,
                                 tag: q_data.record_tag};
    end
    ent_rd <= ent_mem[scan_addr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (em_we) begin
      em_mem[emitted[EIW-1:0]] <= best.seq;
    end
    em_rd <= em_mem[dup_addr[EIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held       <= '0;
      ovf        <= 1'b0;
      rank       <= '0;
      emitted    <= '0;
      have_prev  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      em_pend    <= 1'b0;
      best_found <= 1'b0;
      cons       <= '0;
      scan_addr  <= '0;
      dup_addr   <= '0;
      is_dup     <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            held <= held_new;
            if (!ent_we) ovf <= 1'b1;
            if (q_data.group_end) begin
              cons       <= cons_new;
              scan_addr  <= '0;
              rd_pend    <= 1'b0;
              best_found <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_addr < held) begin
            rd_idx    <= scan_addr[IW-1:0];
            rd_pend   <= 1'b1;
            scan_addr <= scan_addr + 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && after_prev && (!best_found || (ent_rd.key < best.key))) begin
            best       <= ent_rd;
            best_idx   <= rd_idx;
            best_found <= 1'b1;
          end
          if ((scan_addr == held) && !rd_pend) begin
            dup_addr <= '0;
            em_pend  <= 1'b0;
            is_dup   <= 1'b0;
            state    <= ST_DUP;
          end
        end
        ST_DUP: begin
          if (dup_addr < emitted) begin
            dup_addr <= dup_addr + 1'b1;
            em_pend  <= 1'b1;
          end else begin
            em_pend <= 1'b0;
          end
          if (em_pend && (em_rd == best.seq)) is_dup <= 1'b1;
          if ((dup_addr == emitted) && !em_pend) begin
            if (!is_dup) begin
              state <= ST_STORE;
            end else begin
              prev_key  <= best.key;
              prev_idx  <= best_idx;
              have_prev <= 1'b1;
              rank      <= rank_next;
              scan_addr <= '0;
              rd_pend   <= 1'b0;
              best_found <= 1'b0;
              state     <= (rank_next == cons) ? ST_FLUSH : ST_SCAN;
            end
          end
        end
        ST_STORE: begin
          if (store_go) begin
            if (pend_valid) begin
              out_req   <= '{out_tag: pend.tag, out_key: pend.key, out_sequence: pend.seq,
                             out_last: 1'b0, overflowed: ovf};
            end
            pend       <= best;
            pend_valid <= 1'b1;
            emitted    <= emitted + 1'b1;
            prev_key   <= best.key;
            prev_idx   <= best_idx;
            have_prev  <= 1'b1;
            rank       <= rank_next;
            scan_addr  <= '0;
            rd_pend    <= 1'b0;
            best_found <= 1'b0;
            state      <= (rank_next == cons) ? ST_FLUSH : ST_SCAN;
          end
        end
        ST_FLUSH: begin
          if (slot_free) begin
            out_req    <= '{out_tag: pend.tag, out_key: pend.key, out_sequence: pend.seq,
                            out_last: 1'b1, overflowed: ovf};
            pend_valid <= 1'b0;
            held       <= '0;
            ovf        <= 1'b0;
            emitted    <= '0;
            rank       <= '0;
            have_prev  <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "top_k_select_with_dedup_top_assert.svh"

  `TKSD_ASSERT_NEVER(a_held_bound, held > CW'(GROUP_DEPTH))
  `TKSD_ASSERT_NEVER(a_emit_le_rank, emitted > rank)
  `TKSD_ASSERT_PROP(a_flush_has_pend, (state == ST_FLUSH) |-> pend_valid)
  `TKSD_ASSERT_PROP(a_dup_has_best, (state == ST_DUP) |-> best_found)

endmodule
`default_nettype wire
